// File: design/pbss_pkg.sv
// Shared types and constants of the priority bucket slice scheduler.
// Depends on nothing; the top level imports it.
`default_nettype none

package pbss_pkg;

  // result kinds
  localparam logic [2:0] KIND_ADD_OK   = 3'd0;
  localparam logic [2:0] KIND_ADD_REF  = 3'd1;
  localparam logic [2:0] KIND_PROC     = 3'd2;
  localparam logic [2:0] KIND_DISPATCH = 3'd3;
  localparam logic [2:0] KIND_IDLE     = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_SLICE_LENGTH   = 2'd0;
  localparam logic [1:0] CFG_DISPATCH_TICKS = 2'd1;
  localparam logic [1:0] CFG_DISPATCHER_PID = 2'd2;

  // configuration reset values
  localparam logic [7:0]  SLICE_LENGTH_RST   = 8'd5;
  localparam logic [7:0]  DISPATCH_TICKS_RST = 8'd4;
  localparam logic [12:0] DISPATCHER_PID_RST = 13'd6787;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  typedef enum logic [1:0] {
    PH_START,
    PH_SLICE,
    PH_DISPATCH
  } phase_e;

  // one process entry in the entry memory
  typedef struct packed {
    logic [12:0] pid;
    logic [3:0]  prio;
    logic [15:0] rem;
  } ent_t;

endpackage

`default_nettype wire

// File: design/priority_bucket_slice_scheduler.sv
// Multilevel priority queue scheduler: per-level FIFO lists in memory,
// sliced execution with aging and dispatcher ticks. Depends on pbss_pkg.
// An add beat gives its result in the cycle after acceptance; a tick
// beat gives its result after the entry memory read and then the
// read-modify-write in ST_EXEC. Throughput: one add per cycle while not
// busy; busy is high while a tick executes, and no beat is taken then.
// Reset clears control state and restores the register defaults; the entry
// and link memories are not cleared and need no clearing pass.
// Results are strobed for one cycle; the receiver cannot stall.
`default_nettype none

module priority_bucket_slice_scheduler #(
  parameter int MAX_PROCS = 128,
  parameter int LEVELS    = 11
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        action_i,
  input  wire logic [12:0] new_pid_i,
  input  wire logic [3:0]  level_i,
  input  wire logic [15:0] run_time_i,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [12:0] cfg_wdata_i,
  output logic             result_valid_o,
  output logic [2:0]       kind_o,
  output logic [12:0]      pid_o,
  output logic [3:0]       shown_priority_o,
  output logic [15:0]      remaining_o
);
  import pbss_pkg::*;

  localparam int IW  = $clog2(MAX_PROCS);
  localparam int CW  = IW + 1;
  localparam int LVW = $clog2(LEVELS);

  // configuration
  logic [7:0]  slice_length_q, dispatch_ticks_q;
  logic [12:0] dispatcher_pid_q;

  // control state
  state_e            state_q, state_d;
  phase_e            phase_q, phase_d;
  logic              running_q, running_d;
  logic              none_q, none_d;
  logic [IW-1:0]     cur_entry_q, cur_entry_d;
  logic [LVW-1:0]    cur_level_q, cur_level_d;
  logic [7:0]        slice_ticks_q, slice_ticks_d;
  logic [7:0]        dispatch_left_q, dispatch_left_d;
  logic [15:0]       slices_done_q, slices_done_d;
  logic [CW-1:0]     entry_count_q, entry_count_d;
  logic [LEVELS-1:0] nonempty_q, nonempty_d;

  // level list heads and tails
  logic [IW-1:0]  head_q [LEVELS];
  logic [IW-1:0]  tail_q [LEVELS];
  logic           head_we, tail_we;
  logic [LVW-1:0] head_waddr, tail_waddr;
  logic [IW-1:0]  head_wdata, tail_wdata;

  // entry and link memories
  ent_t          ent_mem [MAX_PROCS];
  logic [IW-1:0] next_mem [MAX_PROCS];
  ent_t          ent_rdata, ent_wdata;
  logic [IW-1:0] nxt_rdata, nxt_wdata;
  logic          ent_we, nxt_we;
  logic [IW-1:0] ent_waddr, nxt_waddr, rd_addr;

  // result register
  logic        res_valid_q, res_valid_d;
  logic [2:0]  kind_q, kind_d;
  logic [12:0] pid_q, pid_d;
  logic [3:0]  prio_q, prio_d;
  logic [15:0] rem_q, rem_d;

  // helpers
  logic           accept, add_acc, tick_acc, add_ok;
  logic [LVW-1:0] in_lvl, low_lvl;
  logic           found;
  logic [7:0]     limit, dticks, st, dl_in, dl;
  logic [3:0]     aged, pri_eff;
  logic           in_slice;

  assign accept   = start && (state_q == ST_IDLE);
  assign add_acc  = accept && !action_i;
  assign tick_acc = accept && action_i;
  assign in_lvl   = level_i[LVW-1:0];
  assign add_ok   = !running_q && ({1'b0, level_i} < 5'(LEVELS))
                    && (entry_count_q < CW'(MAX_PROCS));

  // lowest nonempty level
  always_comb begin
    low_lvl = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (nonempty_q[i]) low_lvl = LVW'(i);
    end
  end
  assign found = |nonempty_q;

  assign rd_addr = (phase_q == PH_START) ? head_q[low_lvl] : cur_entry_q;

  // FSM next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (tick_acc) state_d = ST_EXEC;
      ST_EXEC: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    unique case (state_q)
      ST_EXEC: busy = 1'b1;
      default: busy = 1'b0;
    endcase
  end

  assign limit  = (slice_length_q == 8'd0) ? 8'd1 : slice_length_q;
  assign dticks = (dispatch_ticks_q == 8'd0) ? 8'd1 : dispatch_ticks_q;
  assign aged   = (slices_done_q > {12'd0, ent_rdata.prio}) ? 4'd0
                  : ent_rdata.prio - slices_done_q[3:0];
  assign pri_eff  = (phase_q == PH_START) ? aged : ent_rdata.prio;
  assign st       = (phase_q == PH_START) ? 8'd0 : slice_ticks_q;
  assign in_slice = (phase_q == PH_START) || (phase_q == PH_SLICE);
  assign dl_in    = in_slice ? dticks : dispatch_left_q;
  assign dl       = (dl_in != 8'd0) ? dl_in - 8'd1 : 8'd0;

  // datapath
  always_comb begin
    phase_d         = phase_q;
    running_d       = running_q;
    none_d          = none_q;
    cur_entry_d     = cur_entry_q;
    cur_level_d     = cur_level_q;
    slice_ticks_d   = slice_ticks_q;
    dispatch_left_d = dispatch_left_q;
    slices_done_d   = slices_done_q;
    entry_count_d   = entry_count_q;
    nonempty_d      = nonempty_q;
    head_we    = 1'b0;
    head_waddr = in_lvl;
    head_wdata = entry_count_q[IW-1:0];
    tail_we    = 1'b0;
    tail_waddr = in_lvl;
    tail_wdata = entry_count_q[IW-1:0];
    ent_we    = 1'b0;
    ent_waddr = entry_count_q[IW-1:0];
    ent_wdata = '{pid: new_pid_i, prio: level_i, rem: run_time_i};
    nxt_we    = 1'b0;
    nxt_waddr = tail_q[in_lvl];
    nxt_wdata = entry_count_q[IW-1:0];
    res_valid_d = 1'b0;
    kind_d = KIND_IDLE;
    pid_d  = '0;
    prio_d = '0;
    rem_d  = '0;

    if (add_acc) begin
      res_valid_d = 1'b1;
      kind_d      = add_ok ? KIND_ADD_OK : KIND_ADD_REF;
      if (add_ok) begin
        ent_we = 1'b1;
        // append behind the current tail, or open the list
        if (nonempty_q[in_lvl]) begin
          nxt_we = 1'b1;
        end else begin
          head_we            = 1'b1;
          nonempty_d[in_lvl] = 1'b1;
        end
        tail_we       = 1'b1;
        entry_count_d = entry_count_q + CW'(1);
      end
    end

    if (tick_acc) begin
      running_d = 1'b1;
      if (phase_q == PH_START) begin
        none_d = !found;
        if (found) begin
          cur_level_d = low_lvl;
          cur_entry_d = head_q[low_lvl];
        end
      end else begin
        none_d = 1'b0;
      end
    end

    if (state_q == ST_EXEC) begin
      res_valid_d = 1'b1;
      ent_waddr   = cur_entry_q;
      ent_wdata   = '{pid: ent_rdata.pid, prio: pri_eff, rem: ent_rdata.rem};
      if (none_q) begin
        kind_d = KIND_IDLE;
      end else if (in_slice && (st < limit) && (ent_rdata.rem != 16'd0)) begin
        ent_we         = 1'b1;
        ent_wdata.rem  = ent_rdata.rem - 16'd1;
        slice_ticks_d  = st + 8'd1;
        phase_d        = PH_SLICE;
        kind_d         = KIND_PROC;
        pid_d          = ent_rdata.pid;
        prio_d         = pri_eff;
        rem_d          = ent_rdata.rem - 16'd1;
      end else begin
        // write back the aged priority of a slice that ends at once
        ent_we          = (phase_q == PH_START);
        dispatch_left_d = dl;
        phase_d         = PH_DISPATCH;
        kind_d          = KIND_DISPATCH;
        pid_d           = dispatcher_pid_q;
        rem_d           = {8'd0, dl};
        if (dl == 8'd0) begin
          phase_d = PH_START;
          if (slices_done_q != 16'hFFFF) slices_done_d = slices_done_q + 16'd1;
          // drop a finished process from its list
          if (ent_rdata.rem == 16'd0) begin
            if (head_q[cur_level_q] == tail_q[cur_level_q]) begin
              nonempty_d[cur_level_q] = 1'b0;
            end else begin
              head_we    = 1'b1;
              head_waddr = cur_level_q;
              head_wdata = nxt_rdata;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ent_we) ent_mem[ent_waddr] <= ent_wdata;
    ent_rdata <= ent_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (nxt_we) next_mem[nxt_waddr] <= nxt_wdata;
    nxt_rdata <= next_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (head_we) head_q[head_waddr] <= head_wdata;
    if (tail_we) tail_q[tail_waddr] <= tail_wdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slice_length_q   <= SLICE_LENGTH_RST;
      dispatch_ticks_q <= DISPATCH_TICKS_RST;
      dispatcher_pid_q <= DISPATCHER_PID_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SLICE_LENGTH:   slice_length_q   <= cfg_wdata_i[7:0];
        CFG_DISPATCH_TICKS: dispatch_ticks_q <= cfg_wdata_i[7:0];
        CFG_DISPATCHER_PID: dispatcher_pid_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      phase_q         <= PH_START;
      running_q       <= 1'b0;
      none_q          <= 1'b0;
      cur_entry_q     <= '0;
      cur_level_q     <= '0;
      slice_ticks_q   <= '0;
      dispatch_left_q <= '0;
      slices_done_q   <= '0;
      entry_count_q   <= '0;
      nonempty_q      <= '0;
      res_valid_q     <= 1'b0;
    end else begin
      state_q         <= state_d;
      phase_q         <= phase_d;
      running_q       <= running_d;
      none_q          <= none_d;
      cur_entry_q     <= cur_entry_d;
      cur_level_q     <= cur_level_d;
      slice_ticks_q   <= slice_ticks_d;
      dispatch_left_q <= dispatch_left_d;
      slices_done_q   <= slices_done_d;
      entry_count_q   <= entry_count_d;
      nonempty_q      <= nonempty_d;
      res_valid_q     <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    pid_q  <= pid_d;
    prio_q <= prio_d;
    rem_q  <= rem_d;
  end

  assign result_valid_o   = res_valid_q;
  assign kind_o           = kind_q;
  assign pid_o            = pid_q;
  assign shown_priority_o = prio_q;
  assign remaining_o      = rem_q;

  a_add_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && !action_i) |=> result_valid_o)
    else $error("add beat gave no result in the next cycle");

  a_tick_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && action_i) |=> (busy && !result_valid_o) ##1 result_valid_o)
    else $error("tick beat result not two cycles after acceptance");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    entry_count_q <= CW'(MAX_PROCS))
    else $error("entry count beyond capacity");

  a_add_before_ticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && kind_o == KIND_ADD_OK) |-> $past(!running_q))
    else $error("add accepted after ticks began");

  a_proc_tick_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && kind_o == KIND_PROC) |-> (running_q && phase_q == PH_SLICE))
    else $error("process tick outside a slice");

endmodule

`default_nettype wire
